### src/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared widths, types and controller/datapath handshake structs for the
// square-root continued-fraction period block.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int VALUE_WIDTH  = 16;
  localparam int PERIOD_WIDTH = 12;

  // root of a VALUE_WIDTH-bit number
  localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
  // m <= r, d and a <= 2r
  localparam int DW     = HALF_W + 1;
  localparam int PROD_W = 2 * DW;
  // partial remainder for both the root and the divider
  localparam int REM_W  = HALF_W + 2;
  localparam int NSH_W  = 2 * HALF_W;
  localparam int CNT_W  = $clog2(VALUE_WIDTH);

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PERIOD_WIDTH + 2 + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0]  value_t;
  typedef logic [NSH_W-1:0]        nsh_t;
  typedef logic [HALF_W-1:0]       root_t;
  typedef logic [DW-1:0]           dw_t;
  typedef logic [PROD_W-1:0]       prod_t;
  typedef logic [REM_W-1:0]        rem_t;
  typedef logic [PERIOD_WIDTH-1:0] period_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IN_TDATA_W-1:0]   in_tdata_t;
  typedef logic [OUT_TDATA_W-1:0]  out_tdata_t;

  localparam period_t PERIOD_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // latch n, clear root engine
    logic sqrt_step;    // one root digit
    logic init_cf;      // m=0, d=1, a=r, count=0
    logic mul_da;       // prod = d*a
    logic sub_m;        // m = prod - m
    logic mul_mm;       // prod = m*m
    logic div_load_num; // dividend = n - prod
    logic div_load_rm;  // dividend = r + m
    logic div_step;     // one quotient bit
    logic set_d;        // d = quotient
    logic set_a_inc;    // a = quotient, count++
    logic set_sat;      // mark saturated
    logic out_load;     // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sq_zero;    // root remainder is zero: perfect square
    logic q_zero;     // quotient is zero
    logic a_close;    // quotient equals 2r
    logic count_last; // next increment reaches the saturation value
  } stat_t;

endpackage

### src/scfp_ctrl.sv
// ----------------------------------------------------------------------------
// scfp_ctrl
// Sequencer: root digits, per-term multiply/subtract/divide steps, result
// hand-off and output valid.
// ----------------------------------------------------------------------------
module scfp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  scfp_pkg::stat_t  stat,
  output scfp_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SQRT  = 12'b0000_0000_0010,
    S_SQCHK = 12'b0000_0000_0100,
    S_MULA  = 12'b0000_0000_1000,
    S_SUBM  = 12'b0000_0001_0000,
    S_MULB  = 12'b0000_0010_0000,
    S_LDN   = 12'b0000_0100_0000,
    S_DIVN  = 12'b0000_1000_0000,
    S_SETD  = 12'b0001_0000_0000,
    S_DIVA  = 12'b0010_0000_0000,
    S_SETA  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  scfp_pkg::cnt_t cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = scfp_pkg::cnt_t'(scfp_pkg::HALF_W - 1);
          state_nxt   = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SQCHK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SQCHK: begin
        cmd.init_cf = 1'b1;
        state_nxt   = stat.sq_zero ? S_DONE : S_MULA;
      end
      S_MULA: begin
        cmd.mul_da = 1'b1;
        state_nxt  = S_SUBM;
      end
      S_SUBM: begin
        cmd.sub_m = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_mm = 1'b1;
        state_nxt  = S_LDN;
      end
      S_LDN: begin
        cmd.div_load_num = 1'b1;
        cnt_nxt          = scfp_pkg::cnt_t'(scfp_pkg::VALUE_WIDTH - 1);
        state_nxt        = S_DIVN;
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SETD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SETD: begin
        cmd.set_d = 1'b1;
        if (stat.q_zero) begin
          // zero denominator: report as an unclosed expansion
          cmd.set_sat = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_load_rm = 1'b1;
          cnt_nxt         = scfp_pkg::cnt_t'(scfp_pkg::VALUE_WIDTH - 1);
          state_nxt       = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SETA;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_SETA: begin
        cmd.set_a_inc = 1'b1;
        if (stat.a_close) begin
          state_nxt = S_DONE;
        end else if (stat.count_last) begin
          cmd.set_sat = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_MULA;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/scfp_dp.sv
// ----------------------------------------------------------------------------
// scfp_dp
// Datapath: digit-serial integer root, shared multiplier, bit-serial
// restoring divider, term registers and the result register.
// ----------------------------------------------------------------------------
module scfp_dp (
  input  logic               clk,
  input  scfp_pkg::value_t   in_value,
  input  scfp_pkg::cmd_t     cmd,
  output scfp_pkg::stat_t    stat,
  output scfp_pkg::period_t  out_period_length,
  output logic               out_odd_period,
  output logic               out_perfect_square
);

  scfp_pkg::value_t  n_r, n_nxt;
  scfp_pkg::nsh_t    nsh_r, nsh_nxt;
  scfp_pkg::rem_t    srem_r, srem_nxt;
  scfp_pkg::root_t   root_r, root_nxt;
  scfp_pkg::root_t   m_r, m_nxt;
  scfp_pkg::dw_t     d_r, d_nxt;
  scfp_pkg::dw_t     a_r, a_nxt;
  scfp_pkg::prod_t   prod_r, prod_nxt;
  scfp_pkg::value_t  q_r, q_nxt;
  scfp_pkg::rem_t    drem_r, drem_nxt;
  scfp_pkg::period_t count_r, count_nxt;
  logic              sat_r, sat_nxt;
  logic              sq_r, sq_nxt;
  scfp_pkg::period_t oper_r, oper_nxt;
  logic              oodd_r, oodd_nxt;
  logic              osq_r, osq_nxt;

  // root digit: bring down two bits, try (root<<2)|1
  scfp_pkg::rem_t  s_cat, s_trial;
  logic            s_ge;
  // divider step
  scfp_pkg::rem_t  d_sh, d_div;
  logic            d_ge;
  scfp_pkg::dw_t   qd;

  assign s_cat   = scfp_pkg::rem_t'({srem_r, nsh_r[scfp_pkg::NSH_W-1 -: 2]});
  assign s_trial = scfp_pkg::rem_t'({root_r, 2'b01});
  assign s_ge    = (s_cat >= s_trial);

  assign d_sh  = {drem_r[scfp_pkg::REM_W-2:0], q_r[scfp_pkg::VALUE_WIDTH-1]};
  assign d_div = scfp_pkg::rem_t'(d_r);
  assign d_ge  = (d_sh >= d_div);

  assign qd = scfp_pkg::dw_t'(q_r);

  assign stat.sq_zero    = (srem_r == '0);
  assign stat.q_zero     = (qd == '0);
  assign stat.a_close    = (qd == {root_r, 1'b0});
  assign stat.count_last = (count_r == scfp_pkg::PERIOD_MAX - 1'b1);

  assign out_period_length  = oper_r;
  assign out_odd_period     = oodd_r;
  assign out_perfect_square = osq_r;

  always_comb begin
    n_nxt     = n_r;
    nsh_nxt   = nsh_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    a_nxt     = a_r;
    prod_nxt  = prod_r;
    q_nxt     = q_r;
    drem_nxt  = drem_r;
    count_nxt = count_r;
    sat_nxt   = sat_r;
    sq_nxt    = sq_r;
    oper_nxt  = oper_r;
    oodd_nxt  = oodd_r;
    osq_nxt   = osq_r;

    if (cmd.load_in) begin
      n_nxt    = in_value;
      nsh_nxt  = scfp_pkg::nsh_t'(in_value);
      srem_nxt = '0;
      root_nxt = '0;
    end
    if (cmd.sqrt_step) begin
      srem_nxt = s_ge ? (s_cat - s_trial) : s_cat;
      root_nxt = {root_r[scfp_pkg::HALF_W-2:0], s_ge};
      nsh_nxt  = nsh_r << 2;
    end
    if (cmd.init_cf) begin
      m_nxt     = '0;
      d_nxt     = scfp_pkg::dw_t'(1);
      a_nxt     = scfp_pkg::dw_t'(root_r);
      count_nxt = '0;
      sat_nxt   = 1'b0;
      sq_nxt    = (srem_r == '0);
    end
    if (cmd.mul_da) begin
      prod_nxt = scfp_pkg::prod_t'(d_r) * scfp_pkg::prod_t'(a_r);
    end
    if (cmd.sub_m) begin
      m_nxt = scfp_pkg::root_t'(prod_r - scfp_pkg::prod_t'(m_r));
    end
    if (cmd.mul_mm) begin
      prod_nxt = scfp_pkg::prod_t'(m_r) * scfp_pkg::prod_t'(m_r);
    end
    if (cmd.div_load_num) begin
      q_nxt    = n_r - scfp_pkg::value_t'(prod_r);
      drem_nxt = '0;
    end
    if (cmd.div_load_rm) begin
      q_nxt    = scfp_pkg::value_t'(scfp_pkg::dw_t'(root_r) + scfp_pkg::dw_t'(m_r));
      drem_nxt = '0;
    end
    if (cmd.div_step) begin
      drem_nxt = d_ge ? (d_sh - d_div) : d_sh;
      q_nxt    = {q_r[scfp_pkg::VALUE_WIDTH-2:0], d_ge};
    end
    if (cmd.set_d) begin
      d_nxt = qd;
    end
    if (cmd.set_a_inc) begin
      a_nxt     = qd;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.set_sat) begin
      sat_nxt = 1'b1;
    end
    if (cmd.out_load) begin
      oper_nxt = sat_r ? scfp_pkg::PERIOD_MAX : count_r;
      oodd_nxt = !sat_r && count_r[0];
      osq_nxt  = sq_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    nsh_r   <= nsh_nxt;
    srem_r  <= srem_nxt;
    root_r  <= root_nxt;
    m_r     <= m_nxt;
    d_r     <= d_nxt;
    a_r     <= a_nxt;
    prod_r  <= prod_nxt;
    q_r     <= q_nxt;
    drem_r  <= drem_nxt;
    count_r <= count_nxt;
    sat_r   <= sat_nxt;
    sq_r    <= sq_nxt;
    oper_r  <= oper_nxt;
    oodd_r  <= oodd_nxt;
    osq_r   <= osq_nxt;
  end

endmodule

### src/sqrt_continued_fraction_period.sv
// ----------------------------------------------------------------------------
// sqrt_continued_fraction_period
// Period length of the continued fraction of sqrt(n), with odd-period and
// perfect-square flags, computed in exact integer arithmetic.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lsb first)                         | per request
//  --------+-----+--------------------------------------------------+------------
//  in_*    | in  | value[15:0]                                      | one n
//  out_*   | out | period_length[11:0], odd_period, perfect_square, | one result
//          |     | 2 zero pad bits                                  |
//
// Per request the sequencer computes the root, checks it and hands off the
// result, and for each continued-fraction term multiplies, subtracts,
// multiplies and divides twice. The bit-serial divider (one quotient bit a cycle,
// run twice per term) dominates; the root engine takes one digit a cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid. One request is worked at a time; a finished result sits in the
// output register, so the next request is taken while it waits on out_tready.
// A stalled output only holds the block once the next result is ready.
//
module sqrt_continued_fraction_period (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  scfp_pkg::in_tdata_t         in_tdata,   // [15:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output scfp_pkg::out_tdata_t        out_tdata   // [11:0] period_length,
                                                  // [12] odd_period,
                                                  // [13] perfect_square,
                                                  // [15:14] zero
);

  scfp_pkg::cmd_t    cmd;
  scfp_pkg::stat_t   stat;
  scfp_pkg::period_t period_length;
  logic              odd_period;
  logic              perfect_square;

  scfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // bits of in_tdata above the value field are ignored
  scfp_dp u_dp (
    .clk                (clk),
    .in_value           (scfp_pkg::value_t'(in_tdata)),
    .cmd                (cmd),
    .stat               (stat),
    .out_period_length  (period_length),
    .out_odd_period     (odd_period),
    .out_perfect_square (perfect_square)
  );

  assign out_tdata = scfp_pkg::out_tdata_t'({perfect_square, odd_period, period_length});

endmodule

### src/scfp_chk.sv
// ----------------------------------------------------------------------------
// scfp_chk
// Port-level checks for the continued-fraction period block, bound to the
// top level.
// ----------------------------------------------------------------------------
module scfp_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input scfp_pkg::out_tdata_t out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // a perfect square reports period 0 and no odd flag
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[scfp_pkg::PERIOD_WIDTH+1]
      |-> out_tdata[scfp_pkg::PERIOD_WIDTH:0] == '0)
    else $error("perfect square with nonzero period");

  // odd flag agrees with the period
  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[scfp_pkg::PERIOD_WIDTH] |-> out_tdata[0])
    else $error("odd flag on even period");

  // one request in flight: ready drops after a take
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while busy");

endmodule

bind sqrt_continued_fraction_period scfp_chk u_scfp_chk (.*);

### test/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker
// Watches both streams of the continued-fraction period block, predicts the
// result of every accepted request and compares it with the response.
// ----------------------------------------------------------------------------
module scfp_checker
  import scfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  in_tdata_t  in_tdata,        // [15:0] value
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  out_tdata_t out_tdata,       // [11:0] period_length, [12] odd_period,
                                      // [13] perfect_square, [15:14] zero
  output int         fail_count,
  output int         pending,
  output int         squares_seen,
  output int         odd_seen,
  output int         longest_period
);
  timeunit 1ns;
  timeprecision 1ps;

  // same bit order as the low part of out_tdata
  typedef struct packed {
    logic    square;
    logic    odd;
    period_t period;
  } cf_result_t;

  cf_result_t expected_results[$];
  int         errors = 0;

  function automatic cf_result_t cf_period(value_t value);
    longint unsigned n, rem, root, bitv, m, d, a, num, steps, cap;
    logic            closed;
    cf_result_t      res;
    n    = value;
    rem  = n;
    root = 0;
    bitv = 64'd1 << 62;
    cap  = PERIOD_MAX;
    while (bitv > rem) bitv >>= 2;
    // digit-by-digit integer root
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root * root == n) begin
      res.period = '0;
      res.odd    = 1'b0;
      res.square = 1'b1;
      return res;
    end
    m      = 0;
    d      = 1;
    a      = root;
    steps  = 0;
    closed = 1'b0;
    while (steps < cap && !closed) begin
      m   = d * a - m;
      num = n - m * m;
      if (d == 0) break;
      d = num / d;
      if (d == 0) break;
      a     = (root + m) / d;
      steps = steps + 1;
      if (a == 2 * root) closed = 1'b1;
    end
    res.square = 1'b0;
    if (closed) begin
      res.period = period_t'(steps);
      res.odd    = steps[0];
    end else begin
      res.period = PERIOD_MAX;   // never closed: saturate, odd flag cleared
      res.odd    = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    cf_result_t got;
    cf_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      pending <= 0;
    end else begin
      // drain before fill: a response can never belong to this edge's request
      if (out_tvalid && out_tready) begin
        got = out_tdata[PERIOD_WIDTH+1:0];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response with nothing outstanding: period %0d odd %0b square %0b",
                     $realtime, got.period, got.odd, got.square);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[OUT_TDATA_W-1:PERIOD_WIDTH+2] !== '0) begin
            errors++;
            if (errors <= 10)
              $display("%0t: exp p %0d o %0b s %0b, got p %0d o %0b s %0b pad %0b",
                       $realtime, want.period, want.odd, want.square,
                       got.period, got.odd, got.square,
                       out_tdata[OUT_TDATA_W-1:PERIOD_WIDTH+2]);
          end
          if (want.square) squares_seen <= squares_seen + 1;
          if (want.odd) odd_seen <= odd_seen + 1;
          if (int'(want.period) > longest_period) longest_period <= int'(want.period);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(cf_period(in_tdata[VALUE_WIDTH-1:0]));
      pending    <= expected_results.size();
      fail_count <= errors;
    end
  end

endmodule

### test/sqrt_continued_fraction_period_tb.sv
// ----------------------------------------------------------------------------
// sqrt_continued_fraction_period_tb
// Drives square-root period requests into the block with random gaps and
// output back-pressure; a side checker predicts and compares every response.
// ----------------------------------------------------------------------------
module sqrt_continued_fraction_period_tb;
  import scfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Periods below 2^16 stay well under 2000 terms, so this many cycles
  // without any handshake means the block hung.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_COUNT   = 118;
  localparam int DRAIN_CYCLES   = 64;
  localparam int IDLE_PCT       = 6;

  // edges of the range, small squares/non-squares, known odd periods
  // (13 -> 5, 61 -> 11), n = r^2 +/- 1, alternating bit patterns
  localparam int DIRECTED_COUNT = 22;
  localparam value_t DIRECTED [DIRECTED_COUNT] = '{
    16'd0,     16'd1,     16'd2,     16'd3,     16'd4,     16'd5,
    16'd13,    16'd61,    16'd94,    16'd109,   16'd65535, 16'd65534,
    16'd65025, 16'd65026, 16'd65024, 16'd32768, 16'd43690, 16'd21845,
    16'd65280, 16'd1000,  16'd4097,  16'd8191
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  in_tdata_t  in_tdata   = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  out_tdata_t out_tdata;

  int fail_count;
  int pending;
  int squares_seen;
  int odd_seen;
  int longest_period;
  int requests_sent = 0;
  int stall_cycles  = 0;
  bit quiet         = 1'b0;   // no gaps on either side while set

  always #5 clk = ~clk;

  sqrt_continued_fraction_period uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  scfp_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .squares_seen   (squares_seen),
    .odd_seen       (odd_seen),
    .longest_period (longest_period)
  );

  // Receiver: random back-pressure, none while quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request and hold it until accepted. Called right after a
  // rising edge; a gap lowers valid, otherwise valid stays high between
  // back-to-back requests.
  task automatic send_request(input value_t value);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= in_tdata_t'(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Hold off the sender until the checker has nothing outstanding. The first
  // edge lets the checker's count catch up with the last accepted request.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int     pick;
    int     root;
    value_t value;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i]);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      quiet = (i >= 50 && i < 90);   // one stretch with no gaps at all
      if (i == 30) wait_drained();   // sender pauses for a full drain
      pick = $urandom_range(9);
      if (pick < 6) begin
        value = value_t'($urandom_range(65535));
      end else if (pick < 8) begin
        // small n: short expansions
        value = value_t'($urandom_range(999, 2));
      end else begin
        // near a square: r^2, r^2+1, r^2-1 or r^2+r
        root = $urandom_range(255, 1);
        case ($urandom_range(3))
          0:       value = value_t'(root * root);
          1:       value = value_t'(root * root + 1);
          2:       value = value_t'(root * root - 1);
          default: value = value_t'(root * root + root);
        endcase
      end
      send_request(value);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed, rest random) under gaps and back-pressure.",
             requests_sent, DIRECTED_COUNT);
    $display("Saw %0d perfect squares, %0d odd periods, longest period %0d.",
             squares_seen, odd_seen, longest_period);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
src/scfp_pkg.sv
src/scfp_ctrl.sv
src/scfp_dp.sv
src/sqrt_continued_fraction_period.sv
src/scfp_chk.sv
test/scfp_checker.sv
test/sqrt_continued_fraction_period_tb.sv
